// ----- hdl/hbin_pkg.sv -----
// ----------------------------------------------------------------------------
// hbin_pkg: shared types and constants of the histogram density binner
// bin store geometry, arithmetic widths, register indexes, action codes and
// the controller state type
// ----------------------------------------------------------------------------
package hbin_pkg;

  localparam int BINS           = 32;
  localparam int COUNT_BITS     = 20;
  localparam int BIN_BITS       = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int VALUE_BITS     = 32;
  localparam int WIDTH_BITS     = 31;
  localparam int NBINS_BITS     = 6;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIFF_BITS      = VALUE_BITS + 1;
  localparam int BOUND_BITS     = WIDTH_BITS + BIN_BITS + 1;
  localparam int DEN_BITS       = WIDTH_BITS + COUNT_BITS;
  localparam int QUOT_BITS      = 32;
  localparam int DIV_STEP_BITS  = $clog2(QUOT_BITS);

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RANGE_MIN   = 2'd0,
    REG_BIN_WIDTH   = 2'd1,
    REG_BINS_IN_USE = 2'd2
  } cfg_reg_t;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  localparam logic [VALUE_BITS-1:0] RANGE_MIN_RESET   = '0;
  localparam logic [WIDTH_BITS-1:0] BIN_WIDTH_RESET   = WIDTH_BITS'(65536);
  localparam logic [NBINS_BITS-1:0] BINS_IN_USE_RESET = NBINS_BITS'(BINS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ADD_WB,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_EMIT_DIV,
    S_EMIT_OUT
  } state_t;

endpackage

// ----- hdl/histogram_density_binner.sv -----
// ----------------------------------------------------------------------------
// histogram_density_binner: equal-width histogram with density read-out
// q16.16 samples are counted into bins held in a small ram; an emit walks
// the bins and returns center and density for each one
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready, action, sample_value): action add puts
//   one sample into its bin, action emit reads out every bin in use
//   output channel (out_valid/out_ready, bin_center, density, last_bin): one
//   transaction per bin on emit, last_bin marks the final one; add gives none
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
//   write only while the block is idle
// sequencing
//   one input transaction at a time; in_ready is high only when idle
//   add: the bin search, which steps one bound per cycle, and then the
//   read-modify-write of the count ram
//   emit, for each bin: ram read, load, the one-bit restoring divider, output;
//   load goes straight to output when the total is zero or the density
//   saturates
// reset
//   config returns to its reset values, total is cleared and 32 valid bits
//   mark every bin as empty at once, so no clearing pass is needed
// stall
//   a result waits in the output register; the walk holds until it is taken,
//   while the final result may still wait as the next transaction is accepted
// ----------------------------------------------------------------------------
module histogram_density_binner (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic signed [hbin_pkg::VALUE_BITS-1:0] sample_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hbin_pkg::VALUE_BITS-1:0] bin_center,
  output logic [hbin_pkg::QUOT_BITS-1:0]      density,
  output logic                                last_bin,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hbin_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hbin_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration registers
  logic [hbin_pkg::VALUE_BITS-1:0] range_min;
  logic [hbin_pkg::WIDTH_BITS-1:0] bin_width;
  logic [hbin_pkg::NBINS_BITS-1:0] bins_in_use;

  // control state
  hbin_pkg::state_t              state;
  hbin_pkg::state_t              state_next;
  logic [hbin_pkg::BINS-1:0]     bin_valid;
  logic [hbin_pkg::COUNT_BITS-1:0] total;

  // datapath registers
  logic [hbin_pkg::DIFF_BITS-1:0]     diff;
  logic [hbin_pkg::BOUND_BITS-1:0]    bound;
  logic [hbin_pkg::BIN_BITS-1:0]      bin_idx;
  logic [hbin_pkg::VALUE_BITS-1:0]    center;
  logic [hbin_pkg::DEN_BITS-1:0]      den;
  logic [hbin_pkg::DEN_BITS-1:0]      rem;
  logic [hbin_pkg::QUOT_BITS-1:0]     quot;
  logic [hbin_pkg::DIV_STEP_BITS-1:0] div_step;

  // ram port signals
  logic                             ram_rd_en;
  logic                             ram_wr_en;
  logic [hbin_pkg::COUNT_BITS-1:0]  ram_rd_data;
  logic [hbin_pkg::COUNT_BITS-1:0]  ram_wr_data;

  // derived values
  logic [hbin_pkg::WIDTH_BITS-1:0]  w_eff;
  logic [hbin_pkg::NBINS_BITS-1:0]  n_eff;
  logic [hbin_pkg::BIN_BITS-1:0]    n_last;
  logic                             search_more;
  logic [hbin_pkg::COUNT_BITS-1:0]  count_rd;
  logic [hbin_pkg::DEN_BITS:0]      rem_shift;
  logic [hbin_pkg::DEN_BITS:0]      rem_sub;
  logic                             rem_ge;
  logic                             count_sat;
  logic                             out_free;
  logic                             out_load;
  logic                             in_accept;
  logic                             at_last;

  localparam logic [hbin_pkg::DIV_STEP_BITS-1:0] DIV_LAST =
    hbin_pkg::DIV_STEP_BITS'(hbin_pkg::QUOT_BITS - 1);
  localparam logic [hbin_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  assign cfg_ready = 1'b1;

  // zero width acts as one, bin count clamps into 1..BINS
  assign w_eff = (bin_width == '0) ? hbin_pkg::WIDTH_BITS'(1) : bin_width;

  always_comb begin
    n_eff = bins_in_use;
    if (bins_in_use == '0) begin
      n_eff = hbin_pkg::NBINS_BITS'(1);
    end else if (bins_in_use > hbin_pkg::NBINS_BITS'(hbin_pkg::BINS)) begin
      n_eff = hbin_pkg::NBINS_BITS'(hbin_pkg::BINS);
    end
  end

  assign n_last = hbin_pkg::BIN_BITS'(n_eff - hbin_pkg::NBINS_BITS'(1));
  assign at_last = (bin_idx == n_last);

  // step to the next bin while the sample lies above the current upper bound and the last bin in use is not reached
  assign search_more = !diff[hbin_pkg::DIFF_BITS-1]
                    && (hbin_pkg::BOUND_BITS'(diff) > bound)
                    && !at_last;

  // a bin never written since reset reads as zero
  assign count_rd = bin_valid[bin_idx] ? ram_rd_data : '0;

  // one bit of the restoring divider
  assign rem_shift = {rem, 1'b0};
  assign rem_sub   = rem_shift - {1'b0, den};
  assign rem_ge    = (rem_shift >= {1'b0, den});

  // quotient would need more than 32 bits
  assign count_sat = (hbin_pkg::DEN_BITS'(count_rd) >= den);

  assign out_free  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign ram_wr_data = (count_rd == COUNT_MAX) ? count_rd
                                              : count_rd + hbin_pkg::COUNT_BITS'(1);

  hbin_ram #(
    .WIDTH (hbin_pkg::COUNT_BITS),
    .DEPTH (hbin_pkg::BINS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (bin_idx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (bin_idx),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hbin_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (action == hbin_pkg::ACT_EMIT) ? hbin_pkg::S_EMIT_RD
                                                      : hbin_pkg::S_SEARCH;
        end
      end
      hbin_pkg::S_SEARCH: begin
        if (!search_more) begin
          state_next = hbin_pkg::S_ADD_WB;
        end
      end
      hbin_pkg::S_ADD_WB: begin
        state_next = hbin_pkg::S_IDLE;
      end
      hbin_pkg::S_EMIT_RD: begin
        state_next = hbin_pkg::S_EMIT_LOAD;
      end
      hbin_pkg::S_EMIT_LOAD: begin
        state_next = ((total == '0) || count_sat) ? hbin_pkg::S_EMIT_OUT
                                                  : hbin_pkg::S_EMIT_DIV;
      end
      hbin_pkg::S_EMIT_DIV: begin
        if (div_step == DIV_LAST) begin
          state_next = hbin_pkg::S_EMIT_OUT;
        end
      end
      hbin_pkg::S_EMIT_OUT: begin
        if (out_free) begin
          state_next = at_last ? hbin_pkg::S_IDLE : hbin_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = hbin_pkg::S_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      hbin_pkg::S_IDLE:      in_ready  = 1'b1;
      hbin_pkg::S_SEARCH:    ram_rd_en = !search_more;
      hbin_pkg::S_ADD_WB:    ram_wr_en = 1'b1;
      hbin_pkg::S_EMIT_RD:   ram_rd_en = 1'b1;
      hbin_pkg::S_EMIT_OUT:  out_load  = out_free;
      hbin_pkg::S_EMIT_LOAD,
      hbin_pkg::S_EMIT_DIV: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hbin_pkg::S_IDLE;
      range_min   <= hbin_pkg::RANGE_MIN_RESET;
      bin_width   <= hbin_pkg::BIN_WIDTH_RESET;
      bins_in_use <= hbin_pkg::BINS_IN_USE_RESET;
      bin_valid   <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hbin_pkg::REG_RANGE_MIN:   range_min   <= cfg_data;
          hbin_pkg::REG_BIN_WIDTH:   bin_width   <= cfg_data[hbin_pkg::WIDTH_BITS-1:0];
          hbin_pkg::REG_BINS_IN_USE: bins_in_use <= cfg_data[hbin_pkg::NBINS_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (ram_wr_en) begin
        bin_valid[bin_idx] <= 1'b1;
        if (total != COUNT_MAX) begin
          total <= total + hbin_pkg::COUNT_BITS'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      diff    <= {sample_value[hbin_pkg::VALUE_BITS-1], sample_value}
               - {range_min[hbin_pkg::VALUE_BITS-1], range_min};
      bound   <= hbin_pkg::BOUND_BITS'(w_eff);
      bin_idx <= '0;
      center  <= range_min + hbin_pkg::VALUE_BITS'(w_eff >> 1);
      den     <= hbin_pkg::DEN_BITS'(w_eff) * hbin_pkg::DEN_BITS'(total);
    end
    if ((state == hbin_pkg::S_SEARCH) && search_more) begin
      bin_idx <= bin_idx + hbin_pkg::BIN_BITS'(1);
      bound   <= bound + hbin_pkg::BOUND_BITS'(w_eff);
    end
    if (state == hbin_pkg::S_EMIT_LOAD) begin
      rem      <= hbin_pkg::DEN_BITS'(count_rd);
      div_step <= '0;
      if (total == '0) begin
        quot <= '0;
      end else if (count_sat) begin
        quot <= '1;
      end
    end
    if (state == hbin_pkg::S_EMIT_DIV) begin
      div_step <= div_step + hbin_pkg::DIV_STEP_BITS'(1);
      rem      <= rem_ge ? rem_sub[hbin_pkg::DEN_BITS-1:0]
                         : rem_shift[hbin_pkg::DEN_BITS-1:0];
      quot     <= {quot[hbin_pkg::QUOT_BITS-2:0], rem_ge};
    end
    if (out_load) begin
      bin_center <= center;
      density    <= quot;
      last_bin   <= at_last;
      if (!at_last) begin
        bin_idx <= bin_idx + hbin_pkg::BIN_BITS'(1);
        center  <= center + hbin_pkg::VALUE_BITS'(w_eff);
      end
    end
  end

  // every write back stores a count of at least one
  a_wr_nonzero: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (ram_wr_data != '0))
    else $error("count write back of zero");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == hbin_pkg::S_EMIT_DIV) |-> (rem < den))
    else $error("divider remainder out of range");

  // bin search never passes the last bin in use
  a_search_range: assert property (@(posedge clk) disable iff (rst)
    (state == hbin_pkg::S_SEARCH) |-> (bin_idx <= n_last))
    else $error("bin search beyond last bin");

  // with no samples every density reads zero
  a_empty_density: assert property (@(posedge clk) disable iff (rst)
    (out_load && (total == '0)) |=> (density == '0))
    else $error("nonzero density with empty histogram");

endmodule

// ----- hdl/hbin_ram.sv -----
// ----------------------------------------------------------------------------
// hbin_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hbin_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
